[src/pim_pkg.sv]
// Shared types and constants for the PPS interval monitor.
// Used by every module under src; depends on nothing.
package pim_pkg;

   localparam int unsigned CMD_DEPTH = 2;

   localparam logic [31:0] CPS_RESET    = 32'd32768;
   localparam logic        ENABLE_RESET = 1'b1;

   localparam int unsigned TOL_DIVISOR = 20;
   localparam int unsigned TOL_W       = 28;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(CPS_RESET / TOL_DIVISOR);

   // floor(x / 20) == (x * TOL_RECIP) >> TOL_SHIFT for every 32-bit x
   localparam logic [31:0] TOL_RECIP = 32'hCCCC_CCCD;
   localparam int unsigned TOL_SHIFT = 36;

   localparam logic [9:0]  AGE_LIMIT = 10'd1000;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLES_PER_SECOND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE_ENABLE    = 2'd1;

   localparam logic [1:0] OP_EDGE  = 2'd0;
   localparam logic [1:0] OP_CHECK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      KIND_EDGE  = 4'b0001,
      KIND_CHECK = 4'b0010,
      KIND_CLEAR = 4'b0100,
      KIND_NOP   = 4'b1000
   } kind_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] cycle_stamp;
      logic [62:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [31:0] edge_count;
      logic [31:0] interval_count;
      logic [31:0] min_interval;
      logic [31:0] max_interval;
      logic [63:0] interval_sum;
      logic [31:0] last_cycle;
      logic [62:0] last_edge_ms;
      logic        locked;
      logic        edge_usable;
      logic [9:0]  edge_age_ms;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] cycle_stamp;
      logic [62:0] time_ms;
   } cmd_type;

   typedef struct packed {
      logic [31:0]      cycles_per_second;
      logic [TOL_W-1:0] tolerance;
      logic             capture_enable;
   } cfg_type;

   typedef struct packed {
      logic has_item;
      logic has_space;
   } queue_status_type;

endpackage

[src/pps_interval_monitor.sv]
// Top level of the PPS interval monitor: configuration registers, lock window
// tolerance, and the front / queue / back chain. Depends on pim_pkg and all pim_ modules.
//
// Takes one request per clock while req_full is low and returns one result per request,
// in order. A request is classified in the front register, passes the command queue, and
// is applied to the statistics in the back end, which registers the result for popping;
// the statistics update there is combinational, so the back end takes one request per
// cycle while its result buffer has room or is popped. The lock tolerance
// (cycles_per_second / 20) is registered from the cycles_per_second register.
// csr_ready is always high; unknown indexes are ignored.
module pps_interval_monitor #(
   parameter int unsigned QUEUE_DEPTH = pim_pkg::CMD_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  pim_pkg::req_type                req_data,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output pim_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pim_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data
);

   logic [31:0]               cps_ff, cps_in;
   logic                      enable_ff, enable_in;
   logic [pim_pkg::TOL_W-1:0] tol_ff;
   logic [63:0]               tol_product;
   logic                      csr_write;

   pim_pkg::cfg_type          cfg;
   pim_pkg::queue_status_type q_status;
   pim_pkg::cmd_type          front_cmd, head_cmd;
   logic                      q_push, q_pop;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign tol_product = {32'd0, cps_ff} * {32'd0, pim_pkg::TOL_RECIP};

   always_comb begin
      cps_in    = cps_ff;
      enable_in = enable_ff;
      if (csr_write) begin
         case (csr_index)
            pim_pkg::CSR_CYCLES_PER_SECOND: cps_in    = csr_data;
            pim_pkg::CSR_CAPTURE_ENABLE:    enable_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff    <= pim_pkg::CPS_RESET;
         enable_ff <= pim_pkg::ENABLE_RESET;
         tol_ff    <= pim_pkg::TOL_RESET;
      end else begin
         cps_ff    <= cps_in;
         enable_ff <= enable_in;
         tol_ff    <= tol_product[pim_pkg::TOL_SHIFT +: pim_pkg::TOL_W];
      end
   end

   assign cfg.cycles_per_second = cps_ff;
   assign cfg.tolerance         = tol_ff;
   assign cfg.capture_enable    = enable_ff;

   pim_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data       (req_data),
      .req_full       (req_full),
      .capture_enable (enable_ff),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_data         (front_cmd)
   );

   pim_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_cmd),
      .pop       (q_pop),
      .head      (head_cmd),
      .status    (q_status)
   );

   pim_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_status  (q_status),
      .cmd       (head_cmd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_usable_needs_lock: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.edge_usable |-> rsp_data.locked)
      else $error("usable result without lock");

   a_age_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.edge_usable ? rsp_data.edge_age_ms < pim_pkg::AGE_LIMIT
                                           : rsp_data.edge_age_ms == '0))
      else $error("edge age out of range");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.min_interval <= rsp_data.max_interval)
      else $error("minimum interval above maximum");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> rsp_empty)
      else $error("result pending right after reset");

endmodule

[src/pim_front.sv]
// Front end of the PPS interval monitor: accepts requests and classifies them.
// Depends on pim_pkg; feeds pim_queue.
module pim_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  pim_pkg::req_type          req_data,
   output logic                      req_full,
   input  logic                      capture_enable,
   input  pim_pkg::queue_status_type q_status,
   output logic                      q_push,
   output pim_pkg::cmd_type          q_data
);

   logic             valid_ff, valid_in;
   pim_pkg::cmd_type cmd_ff, cmd_in;
   pim_pkg::kind_type kind;
   logic             accept;

   always_comb begin
      case (req_data.opcode)
         pim_pkg::OP_EDGE:  kind = capture_enable ? pim_pkg::KIND_EDGE : pim_pkg::KIND_NOP;
         pim_pkg::OP_CHECK: kind = capture_enable ? pim_pkg::KIND_CHECK : pim_pkg::KIND_NOP;
         pim_pkg::OP_CLEAR: kind = pim_pkg::KIND_CLEAR;
         default:           kind = pim_pkg::KIND_NOP;
      endcase
   end

   assign q_push   = valid_ff && q_status.has_space;
   assign req_full = valid_ff && !q_status.has_space;
   assign accept   = req_push && !req_full;
   assign q_data   = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in           = 1'b1;
         cmd_in.kind        = kind;
         cmd_in.cycle_stamp = req_data.cycle_stamp;
         cmd_in.time_ms     = req_data.time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

[src/pim_queue.sv]
// Command queue between the front and back ends of the PPS interval monitor.
// Depends on pim_pkg.
module pim_queue #(
   parameter int unsigned DEPTH = pim_pkg::CMD_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pim_pkg::cmd_type          push_data,
   input  logic                      pop,
   output pim_pkg::cmd_type          head,
   output pim_pkg::queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   pim_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.has_item  = count_ff != '0;
   assign status.has_space = count_ff != CNT_W'(DEPTH);
   assign do_push = push && status.has_space;
   assign do_pop  = pop && status.has_item;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/pim_back.sv]
// Back end of the PPS interval monitor: applies commands to the statistics
// and queues results. Depends on pim_pkg; fed by pim_queue.
module pim_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pim_pkg::cfg_type          cfg,
   input  pim_pkg::queue_status_type q_status,
   input  pim_pkg::cmd_type          cmd,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output pim_pkg::rsp_type          rsp_data
);

   logic [31:0] edges_ff, edges_in;
   logic [31:0] intervals_ff, intervals_in;
   logic [31:0] shortest_ff, shortest_in;
   logic [31:0] longest_ff, longest_in;
   logic [63:0] total_ff, total_in;
   logic [31:0] prev_cycle_ff, prev_cycle_in;
   logic [62:0] prev_ms_ff, prev_ms_in;
   logic        lock_ff, lock_in;

   pim_pkg::rsp_type out_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   logic        go, out_pop;
   logic [31:0] diff;
   logic [62:0] age_full;
   logic [32:0] win_lo, win_hi;
   logic        in_window;
   logic        usable;
   logic [9:0]  age;
   pim_pkg::rsp_type result;

   assign out_pop   = rsp_pop && count_ff != 2'd0;
   assign go        = q_status.has_item && (count_ff != 2'd2 || out_pop);
   assign q_pop     = go;
   assign rsp_empty = count_ff == 2'd0;
   assign rsp_data  = out_ff[rd_ptr_ff];

   assign diff      = cmd.cycle_stamp - prev_cycle_ff;
   assign age_full  = cmd.time_ms - prev_ms_ff;
   assign win_lo    = {1'b0, cfg.cycles_per_second} - {5'd0, cfg.tolerance};
   assign win_hi    = {1'b0, cfg.cycles_per_second} + {5'd0, cfg.tolerance};
   assign in_window = ({1'b0, diff} > win_lo) && ({1'b0, diff} < win_hi);

   always_comb begin
      edges_in      = edges_ff;
      intervals_in  = intervals_ff;
      shortest_in   = shortest_ff;
      longest_in    = longest_ff;
      total_in      = total_ff;
      prev_cycle_in = prev_cycle_ff;
      prev_ms_in    = prev_ms_ff;
      lock_in       = lock_ff;
      usable        = 1'b0;
      age           = '0;
      case (cmd.kind)
         pim_pkg::KIND_EDGE: begin
            if (edges_ff != '0) begin
               if (intervals_ff == '0 || diff < shortest_ff) begin
                  shortest_in = diff;
               end
               if (intervals_ff == '0 || diff > longest_ff) begin
                  longest_in = diff;
               end
               total_in     = total_ff + {32'd0, diff};
               intervals_in = intervals_ff + 1'b1;
               lock_in      = in_window;
            end
            prev_cycle_in = cmd.cycle_stamp;
            prev_ms_in    = cmd.time_ms;
            edges_in      = edges_ff + 1'b1;
         end
         pim_pkg::KIND_CHECK: begin
            if (lock_ff && cmd.time_ms >= prev_ms_ff
                && age_full < {53'd0, pim_pkg::AGE_LIMIT}) begin
               usable = 1'b1;
               age    = age_full[9:0];
            end
         end
         pim_pkg::KIND_CLEAR: begin
            edges_in      = '0;
            intervals_in  = '0;
            shortest_in   = '0;
            longest_in    = '0;
            total_in      = '0;
            prev_cycle_in = '0;
            prev_ms_in    = '0;
            lock_in       = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.edge_count     = edges_in;
      result.interval_count = intervals_in;
      result.min_interval   = shortest_in;
      result.max_interval   = longest_in;
      result.interval_sum   = total_in;
      result.last_cycle     = prev_cycle_in;
      result.last_edge_ms   = prev_ms_in;
      result.locked         = lock_in;
      result.edge_usable    = usable;
      result.edge_age_ms    = age;
   end

   always_comb begin
      count_in = count_ff;
      if (go && !out_pop) begin
         count_in = count_ff + 2'd1;
      end else if (out_pop && !go) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff      <= '0;
         intervals_ff  <= '0;
         shortest_ff   <= '0;
         longest_ff    <= '0;
         total_ff      <= '0;
         prev_cycle_ff <= '0;
         prev_ms_ff    <= '0;
         lock_ff       <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (go) begin
            edges_ff      <= edges_in;
            intervals_ff  <= intervals_in;
            shortest_ff   <= shortest_in;
            longest_ff    <= longest_in;
            total_ff      <= total_in;
            prev_cycle_ff <= prev_cycle_in;
            prev_ms_ff    <= prev_ms_in;
            lock_ff       <= lock_in;
            wr_ptr_ff     <= !wr_ptr_ff;
         end
         if (out_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
      if (go) begin
         out_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

[bench/pps_interval_monitor_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for pps_interval_monitor: directed edge, check and clear cases,
// then random pulse trains under several rate settings and idle patterns.
// Depends on pim_pkg and the RTL under src; the statistics are predicted in a scoreboard.

class pps_stats_scoreboard;
   logic [31:0] nominal_cycles;
   logic        capture_on;
   logic [31:0] edges_seen;
   logic [31:0] intervals_seen;
   logic [31:0] shortest;
   logic [31:0] longest;
   logic [63:0] total;
   logic [31:0] prev_cycle;
   logic [62:0] prev_ms;
   logic        lock_flag;
   pim_pkg::rsp_type expected_stats[$];
   int          mismatch_count;

   function new();
      nominal_cycles = pim_pkg::CPS_RESET;
      capture_on = pim_pkg::ENABLE_RESET;
      mismatch_count = 0;
      clear_stats();
   endfunction

   function void clear_stats();
      edges_seen = '0;
      intervals_seen = '0;
      shortest = '0;
      longest = '0;
      total = '0;
      prev_cycle = '0;
      prev_ms = '0;
      lock_flag = 1'b0;
   endfunction

   function void write_register(logic [pim_pkg::CSR_INDEX_W-1:0] index, logic [31:0] value);
      case (index)
         pim_pkg::CSR_CYCLES_PER_SECOND: nominal_cycles = value;
         pim_pkg::CSR_CAPTURE_ENABLE: capture_on = value[0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_stats.size();
   endfunction

   function void note_request(pim_pkg::req_type req);
      pim_pkg::rsp_type stats;
      logic [31:0] gap;
      logic [32:0] nominal;
      logic [32:0] slack;
      logic [62:0] age;
      stats = '0;
      case (req.opcode)
         pim_pkg::OP_EDGE: begin
            if (capture_on) begin
               if (edges_seen != 0) begin
                  gap = req.cycle_stamp - prev_cycle;
                  if (intervals_seen == 0 || gap < shortest) shortest = gap;
                  if (intervals_seen == 0 || gap > longest) longest = gap;
                  total = total + 64'(gap);
                  intervals_seen = intervals_seen + 32'd1;
                  nominal = {1'b0, nominal_cycles};
                  slack = nominal / 33'(pim_pkg::TOL_DIVISOR);
                  lock_flag = ({1'b0, gap} > nominal - slack) &&
                              ({1'b0, gap} < nominal + slack);
               end
               prev_cycle = req.cycle_stamp;
               prev_ms = req.time_ms;
               edges_seen = edges_seen + 32'd1;
            end
         end
         pim_pkg::OP_CHECK: begin
            age = req.time_ms - prev_ms;
            if (capture_on && lock_flag && req.time_ms >= prev_ms &&
                age < 63'(pim_pkg::AGE_LIMIT)) begin
               stats.edge_usable = 1'b1;
               stats.edge_age_ms = age[9:0];
            end
         end
         pim_pkg::OP_CLEAR: clear_stats();
         default: ;
      endcase
      stats.edge_count = edges_seen;
      stats.interval_count = intervals_seen;
      stats.min_interval = shortest;
      stats.max_interval = longest;
      stats.interval_sum = total;
      stats.last_cycle = prev_cycle;
      stats.last_edge_ms = prev_ms;
      stats.locked = lock_flag;
      expected_stats.push_back(stats);
   endfunction

   function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   function void check_response(pim_pkg::rsp_type got);
      pim_pkg::rsp_type want;
      if (expected_stats.size() == 0) begin
         $error("result transfer with no expected statistics pending");
         mismatch_count++;
         return;
      end
      want = expected_stats.pop_front();
      compare_field("edge_count", 64'(want.edge_count), 64'(got.edge_count));
      compare_field("interval_count", 64'(want.interval_count), 64'(got.interval_count));
      compare_field("min_interval", 64'(want.min_interval), 64'(got.min_interval));
      compare_field("max_interval", 64'(want.max_interval), 64'(got.max_interval));
      compare_field("interval_sum", want.interval_sum, got.interval_sum);
      compare_field("last_cycle", 64'(want.last_cycle), 64'(got.last_cycle));
      compare_field("last_edge_ms", 64'(want.last_edge_ms), 64'(got.last_edge_ms));
      compare_field("locked", 64'(want.locked), 64'(got.locked));
      compare_field("edge_usable", 64'(want.edge_usable), 64'(got.edge_usable));
      compare_field("edge_age_ms", 64'(want.edge_age_ms), 64'(got.edge_age_ms));
   endfunction
endclass

module pps_interval_monitor_test;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [62:0] MS_MAX        = '1;
   localparam logic [pim_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   pim_pkg::req_type                req_data = '0;
   logic                            req_full;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   pim_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pim_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                     csr_data = '0;

   pps_stats_scoreboard board;
   int unsigned send_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   int unsigned cycle_count = 0;
   logic [31:0] stim_cps = pim_pkg::CPS_RESET;
   logic [31:0] stim_cycle = '0;
   logic [62:0] stim_ms = '0;

   pps_interval_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) board.note_request(req_data);
         if (rsp_pop && !rsp_empty) board.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [62:0] random_ms();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[62:0];
   endfunction

   function automatic pim_pkg::req_type make_req(logic [1:0] op, logic [31:0] cyc,
                                                 logic [62:0] ms);
      pim_pkg::req_type req;
      req.opcode = op;
      req.cycle_stamp = cyc;
      req.time_ms = ms;
      return req;
   endfunction

   // drop push, then hold until every expected result is back and the pipe is empty
   task automatic wait_drained();
      @(negedge clock) req_push <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [pim_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_register(index, value);
      if (index == pim_pkg::CSR_CYCLES_PER_SECOND) stim_cps = value;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic send_request(input pim_pkg::req_type req);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (req_full);
      if (req.opcode == pim_pkg::OP_EDGE) begin
         stim_cycle = req.cycle_stamp;
         stim_ms = req.time_ms;
      end
   endtask

   task automatic run_phase(input logic [31:0] cps, input logic enable,
                            input idle_mode_type mode, input int count);
      pim_pkg::req_type req;
      logic [31:0] slack;
      logic [31:0] step;
      int unsigned pick;
      write_csr(pim_pkg::CSR_CYCLES_PER_SECOND, cps);
      write_csr(pim_pkg::CSR_CAPTURE_ENABLE, 32'(enable));
      send_idle_pct = (mode == IDLE_SENDER) ? 66 : (mode == IDLE_BOTH) ? 27 : 0;
      pop_stall_pct = (mode == IDLE_RECEIVER) ? 66 : (mode == IDLE_BOTH) ? 27 : 0;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_drained();
         pick = $urandom_range(0, 99);
         req = make_req(pim_pkg::OP_EDGE, $urandom, random_ms());
         if (pick < 55) begin
            slack = stim_cps / 32'(pim_pkg::TOL_DIVISOR);
            case ($urandom_range(0, 9))
               0: step = stim_cps - slack;
               1: step = stim_cps + slack;
               2: step = $urandom;
               default: step = stim_cps - slack - 1 + $urandom_range(0, 2 * slack + 2);
            endcase
            req.cycle_stamp = stim_cycle + step;
            req.time_ms = stim_ms + 63'(990 + $urandom_range(0, 20));
         end else if (pick < 80) begin
            req.opcode = pim_pkg::OP_CHECK;
            case ($urandom_range(0, 9))
               0: req.time_ms = stim_ms - 63'($urandom_range(1, 100));
               1: req.time_ms = stim_ms + 63'd999;
               2: req.time_ms = stim_ms + 63'd1000;
               default: req.time_ms = stim_ms + 63'($urandom_range(0, 1100));
            endcase
         end else if (pick < 83) begin
            req.opcode = pim_pkg::OP_CLEAR;
         end else if (pick < 86) begin
            req.opcode = OP_UNUSED;
         end else if (pick < 93) begin
            req.opcode = pim_pkg::OP_CHECK;
         end
         send_request(req);
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, 63'd5));
      send_request(make_req(pim_pkg::OP_EDGE, 32'd0, 63'd0));
      send_request(make_req(pim_pkg::OP_EDGE, 32'd32768, 63'd1000));
      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, 63'd1000));
      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, 63'd1999));
      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, 63'd2000));
      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, 63'd999));
      // lock window edges at the reset rate: 31130 and 34406 lie outside
      send_request(make_req(pim_pkg::OP_EDGE, 32'd63898, 63'd2000));
      send_request(make_req(pim_pkg::OP_EDGE, 32'd95029, 63'd3000));
      send_request(make_req(pim_pkg::OP_EDGE, 32'd129435, 63'd4000));
      send_request(make_req(pim_pkg::OP_EDGE, 32'd163840, 63'd5000));
      send_request(make_req(pim_pkg::OP_EDGE, 32'hFFFF_FFFF, 63'd6000));
      send_request(make_req(pim_pkg::OP_EDGE, 32'h0000_7FFF, MS_MAX));
      send_request(make_req(pim_pkg::OP_CHECK, 32'hFFFF_FFFF, MS_MAX));
      send_request(make_req(OP_UNUSED, 32'hFFFF_FFFF, MS_MAX));

      write_csr(pim_pkg::CSR_CAPTURE_ENABLE, 32'd0);
      send_request(make_req(pim_pkg::OP_EDGE, 32'd5, 63'd7));
      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, MS_MAX));
      send_request(make_req(pim_pkg::OP_CLEAR, 32'd0, 63'd0));
      write_csr(pim_pkg::CSR_CAPTURE_ENABLE, 32'd1);
      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, MS_MAX));

      write_csr(pim_pkg::CSR_CYCLES_PER_SECOND, 32'd0);
      send_request(make_req(pim_pkg::OP_EDGE, 32'd0, 63'd10));
      send_request(make_req(pim_pkg::OP_EDGE, 32'd0, 63'd20));
      write_csr(pim_pkg::CSR_CYCLES_PER_SECOND, 32'hFFFF_FFFF);
      write_csr(CSR_UNMAPPED, 32'd0);
      send_request(make_req(pim_pkg::OP_EDGE, 32'hFFFF_FFFF, 63'd30));
      send_request(make_req(pim_pkg::OP_CHECK, 32'd0, 63'd30));
      write_csr(pim_pkg::CSR_CYCLES_PER_SECOND, 32'd1);
      send_request(make_req(pim_pkg::OP_EDGE, 32'd0, 63'd40));

      run_phase(32'd32768, 1'b1, IDLE_NONE, 200);
      run_phase(32'd32768, 1'b1, IDLE_SENDER, 200);
      run_phase(32'd1, 1'b1, IDLE_RECEIVER, 150);
      run_phase(32'hFFFF_FFFF, 1'b1, IDLE_BOTH, 200);
      run_phase(32'd10_000_000, 1'b0, IDLE_BOTH, 80);
      run_phase(32'd0, 1'b1, IDLE_NONE, 100);
      run_phase(32'd50_000_000, 1'b1, IDLE_RECEIVER, 200);
      run_phase($urandom, 1'b1, IDLE_SENDER, 200);
      run_phase(32'd19, 1'b1, IDLE_BOTH, 100);

      wait_drained();
      if (board.mismatch_count == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
src/pim_pkg.sv
src/pim_front.sv
src/pim_queue.sv
src/pim_back.sv
src/pps_interval_monitor.sv
bench/pps_interval_monitor_test.sv
